@@ src/assert_macros.svh @@
// Assertion helpers used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every edge outside reset.
`define HTDB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check on every edge, reset included.
`define HTDB_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("reset assertion failed");

`endif

@@ src/htdb_pkg.sv @@
package htdb_pkg;

  localparam int LANES         = 4;
  localparam int SAMPLE_FIELDS = 4;
  localparam int SCAN_LANES    = (LANES < SAMPLE_FIELDS) ? LANES : SAMPLE_FIELDS;

  localparam int SAMPLE_W = 24;
  localparam int HOLD_W   = 24;
  localparam int COUNT_W  = 25;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [1:0] REG_TRIGGER_LEVEL = 2'd0;
  localparam logic [1:0] REG_REST_LEVEL    = 2'd1;
  localparam logic [1:0] REG_TRIGGER_HOLD  = 2'd2;
  localparam logic [1:0] REG_REST_HOLD     = 2'd3;

  localparam logic ACTION_SAMPLES = 1'b0;
  localparam logic ACTION_CONTROL = 1'b1;

  localparam logic EVENT_TRIGGER = 1'b0;
  localparam logic EVENT_REST    = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] trigger_level;
    logic signed [SAMPLE_W-1:0] rest_level;
  } htdb_thr_t;

  typedef struct packed {
    logic fire;
    logic kind;
  } htdb_evt_t;

endpackage

@@ src/htdb_lane.sv @@
module htdb_lane (
  input  htdb_pkg::sample_t  sample,
  input  htdb_pkg::htdb_thr_t thr,
  input  logic               armed,
  output logic               hit
);
  import htdb_pkg::*;

  logic above_trigger;
  logic below_rest;

  assign above_trigger = (sample >= thr.trigger_level);
  assign below_rest    = (sample < thr.rest_level);
  assign hit           = armed ? above_trigger : below_rest;

endmodule

@@ src/htdb_merge.sv @@
module htdb_merge (
  input  logic [htdb_pkg::SCAN_LANES-1:0] lane_hit,
  input  logic                            armed,
  output htdb_pkg::htdb_evt_t             evt
);
  import htdb_pkg::*;

  always_comb begin
    evt.fire = |lane_hit;
    evt.kind = armed ? EVENT_TRIGGER : EVENT_REST;
  end

endmodule

@@ src/hysteresis_threshold_debounce_core.sv @@
// An event is registered into out_valid, or into the skid entry when the output stalls.
// One word per cycle unless stalled; all lanes compare in parallel in the accept cycle.
// A two-entry output stage (register plus skid) raises in_stall only when both are full.
// Sync reset (rst_n low): armed, no hold-off, count zero, config and valid flags zero.
module hysteresis_threshold_debounce_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  htdb_pkg::sample_t             in_sample_0,
  input  htdb_pkg::sample_t             in_sample_1,
  input  htdb_pkg::sample_t             in_sample_2,
  input  htdb_pkg::sample_t             in_sample_3,
  input  logic                          in_control_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_event_kind,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [htdb_pkg::ADDR_W-1:0]   paddr,
  input  logic [htdb_pkg::DATA_W-1:0]   pwdata,
  output logic [htdb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import htdb_pkg::*;
  `include "assert_macros.svh"

  sample_t                 trigger_level_r;
  sample_t                 rest_level_r;
  logic [HOLD_W-1:0]       trigger_hold_r;
  logic [HOLD_W-1:0]       rest_hold_r;

  logic                    armed_r, armed_nxt;
  logic                    trig_holding_r, trig_holding_nxt;
  logic                    rest_holding_r, rest_holding_nxt;
  logic [COUNT_W-1:0]      hold_count_r, hold_count_nxt;

  logic                    out_valid_r;
  logic                    out_kind_r;
  logic                    skid_valid_r;
  logic                    skid_kind_r;

  logic                    cfg_wr;
  logic [1:0]              cfg_idx;
  logic                    in_accept;
  logic                    res_valid;
  logic                    res_kind;
  logic [COUNT_W-1:0]      count_adv;
  logic [COUNT_W-1:0]      hold_limit;
  logic                    out_free;

  sample_t                 sample_arr [SAMPLE_FIELDS];
  logic [SCAN_LANES-1:0]   lane_hit;
  htdb_thr_t               thr;
  htdb_evt_t               evt;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_level_r <= '0;
      rest_level_r    <= '0;
      trigger_hold_r  <= '0;
      rest_hold_r     <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TRIGGER_LEVEL: trigger_level_r <= pwdata[SAMPLE_W-1:0];
        REG_REST_LEVEL:    rest_level_r    <= pwdata[SAMPLE_W-1:0];
        REG_TRIGGER_HOLD:  trigger_hold_r  <= pwdata[HOLD_W-1:0];
        REG_REST_HOLD:     rest_hold_r     <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TRIGGER_LEVEL: prdata = DATA_W'(trigger_level_r);
      REG_REST_LEVEL:    prdata = DATA_W'(rest_level_r);
      REG_TRIGGER_HOLD:  prdata = {{(DATA_W-HOLD_W){1'b0}}, trigger_hold_r};
      REG_REST_HOLD:     prdata = {{(DATA_W-HOLD_W){1'b0}}, rest_hold_r};
      default:           prdata = '0;
    endcase
  end

  assign sample_arr[0] = in_sample_0;
  assign sample_arr[1] = in_sample_1;
  assign sample_arr[2] = in_sample_2;
  assign sample_arr[3] = in_sample_3;

  assign thr.trigger_level = trigger_level_r;
  assign thr.rest_level    = rest_level_r;

  for (genvar g = 0; g < SCAN_LANES; g++) begin : g_lane
    htdb_lane u_lane (
      .sample (sample_arr[g]),
      .thr    (thr),
      .armed  (armed_r),
      .hit    (lane_hit[g])
    );
  end

  htdb_merge u_merge (
    .lane_hit (lane_hit),
    .armed    (armed_r),
    .evt      (evt)
  );

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid & ~in_stall;

  assign count_adv  = hold_count_r + COUNT_W'(LANES);
  assign hold_limit = trig_holding_r ? {1'b0, trigger_hold_r} : {1'b0, rest_hold_r};

  always_comb begin
    armed_nxt        = armed_r;
    trig_holding_nxt = trig_holding_r;
    rest_holding_nxt = rest_holding_r;
    hold_count_nxt   = hold_count_r;
    res_valid        = 1'b0;
    res_kind         = evt.kind;
    if (in_accept) begin
      if (in_action == ACTION_CONTROL) begin
        armed_nxt        = ~in_control_value;
        trig_holding_nxt = 1'b0;
        rest_holding_nxt = 1'b0;
        hold_count_nxt   = '0;
      end else if (trig_holding_r || rest_holding_r) begin
        if (count_adv >= hold_limit) begin
          trig_holding_nxt = 1'b0;
          rest_holding_nxt = 1'b0;
          hold_count_nxt   = '0;
        end else begin
          hold_count_nxt = count_adv;
        end
      end else if (evt.fire) begin
        res_valid = 1'b1;
        armed_nxt = ~armed_r;
        if (armed_r) begin
          trig_holding_nxt = 1'b1;
        end else begin
          rest_holding_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r        <= 1'b1;
      trig_holding_r <= 1'b0;
      rest_holding_r <= 1'b0;
      hold_count_r   <= '0;
    end else begin
      armed_r        <= armed_nxt;
      trig_holding_r <= trig_holding_nxt;
      rest_holding_r <= rest_holding_nxt;
      hold_count_r   <= hold_count_nxt;
    end
  end

  assign out_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_kind_r <= skid_valid_r ? skid_kind_r : res_kind;
    end
    if (!out_free && res_valid) begin
      skid_kind_r <= res_kind;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;

  `HTDB_ASSERT(a_one_holdoff, !(trig_holding_r && rest_holding_r))
  `HTDB_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r)
  `HTDB_ASSERT(a_count_only_holding, (hold_count_r != '0) |-> (trig_holding_r || rest_holding_r))
  `HTDB_ASSERT(a_control_clears, (in_accept && in_action == ACTION_CONTROL) |=> (!trig_holding_r && !rest_holding_r && hold_count_r == '0))
  `HTDB_ASSERT_RST(a_reset_armed, !rst_n |=> (armed_r && !out_valid_r && !skid_valid_r))

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import htdb_pkg::*;

  localparam logic CTRL_ARM       = 1'b0;
  localparam logic CTRL_WAIT_REST = 1'b1;
  localparam sample_t SMP_MAX = 24'sh7FFFFF;
  localparam sample_t SMP_MIN = 24'sh800000;
  localparam logic [HOLD_W-1:0] HOLD_MAX = 24'hFFFFFF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 130;

  class debounce_scoreboard;
    sample_t trig_lvl;
    sample_t rest_lvl;
    logic [HOLD_W-1:0] trig_hold;
    logic [HOLD_W-1:0] rest_hold;
    bit armed;
    bit trig_holding;
    bit rest_holding;
    logic [COUNT_W-1:0] hold_cnt;
    logic awaited_events[$];
    int errors;

    function new();
      trig_lvl = '0;
      rest_lvl = '0;
      trig_hold = '0;
      rest_hold = '0;
      armed = 1'b1;
      trig_holding = 1'b0;
      rest_holding = 1'b0;
      hold_cnt = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_TRIGGER_LEVEL: trig_lvl = val[SAMPLE_W-1:0];
        REG_REST_LEVEL:    rest_lvl = val[SAMPLE_W-1:0];
        REG_TRIGGER_HOLD:  trig_hold = val[HOLD_W-1:0];
        REG_REST_HOLD:     rest_hold = val[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function void step_hold(logic [HOLD_W-1:0] lim);
      hold_cnt = hold_cnt + COUNT_W'(LANES);
      if (hold_cnt >= {1'b0, lim}) begin
        hold_cnt = '0;
        trig_holding = 1'b0;
        rest_holding = 1'b0;
      end
    endfunction

    function void note_word(logic act, logic [4*SAMPLE_W-1:0] smp, logic ctl);
      sample_t lane;
      if (act == ACTION_CONTROL) begin
        armed = (ctl == CTRL_ARM);
        trig_holding = 1'b0;
        rest_holding = 1'b0;
        hold_cnt = '0;
        return;
      end
      if (trig_holding) begin
        step_hold(trig_hold);
        return;
      end
      if (rest_holding) begin
        step_hold(rest_hold);
        return;
      end
      for (int i = 0; i < SCAN_LANES; i++) begin
        lane = smp[i*SAMPLE_W +: SAMPLE_W];
        if (armed && lane >= trig_lvl) begin
          trig_holding = 1'b1;
          armed = 1'b0;
          awaited_events.push_back(EVENT_TRIGGER);
          return;
        end
        if (!armed && lane < rest_lvl) begin
          rest_holding = 1'b1;
          armed = 1'b1;
          awaited_events.push_back(EVENT_REST);
          return;
        end
      end
    endfunction

    function void check_event(logic kind);
      logic want;
      if (awaited_events.size() == 0) begin
        $error("event_kind: expected no event, actual %0d", kind);
        errors++;
        return;
      end
      want = awaited_events.pop_front();
      if (want !== kind) begin
        $error("event_kind: expected %0d, actual %0d", want, kind);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = ACTION_SAMPLES;
  sample_t in_sample_0 = '0;
  sample_t in_sample_1 = '0;
  sample_t in_sample_2 = '0;
  sample_t in_sample_3 = '0;
  logic in_control_value = CTRL_ARM;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_event_kind;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  debounce_scoreboard sb;
  bit offering = 1'b0;
  bit gaps_on = 1'b1;
  int squeeze_req = 0;
  int squeeze_seen = 0;
  int stall_left = 0;
  int free_left = 0;
  int cycle_count = 0;

  hysteresis_threshold_debounce_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_sample_0(in_sample_0),
    .in_sample_1(in_sample_1),
    .in_sample_2(in_sample_2),
    .in_sample_3(in_sample_3),
    .in_control_value(in_control_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_kind(out_event_kind),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_event(out_event_kind);
    end
  end

  // hold off long on request, else alternate free runs and short or long stalls
  always @(posedge clk) begin
    int r;
    if (squeeze_seen != squeeze_req) begin
      squeeze_seen = squeeze_req;
      stall_left = 400;
      free_left = 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      r = $urandom_range(0, 9);
      free_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
      if (r < 6) begin
        stall_left = $urandom_range(1, 2);
      end else if (r < 9) begin
        stall_left = $urandom_range(3, 6);
      end else begin
        stall_left = $urandom_range(15, 40);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [SAMPLE_W-1:0] val);
    logic [31:0] rnd;
    logic [DATA_W-1:0] word;
    rnd = $urandom;
    word = {rnd[31:24], val};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, word);
    @(posedge clk);
  endtask

  task automatic push_word(input logic act, input logic [4*SAMPLE_W-1:0] smp,
                           input logic ctl);
    int gap;
    int r;
    in_valid <= 1'b1;
    offering = 1'b1;
    in_action <= act;
    in_sample_0 <= smp[0*SAMPLE_W +: SAMPLE_W];
    in_sample_1 <= smp[1*SAMPLE_W +: SAMPLE_W];
    in_sample_2 <= smp[2*SAMPLE_W +: SAMPLE_W];
    in_sample_3 <= smp[3*SAMPLE_W +: SAMPLE_W];
    in_control_value <= ctl;
    do @(posedge clk); while (in_stall);
    sb.note_word(act, smp, ctl);
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 92) begin
        gap = $urandom_range(8, 40);
      end else if (r >= 70) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_samples(input sample_t a, input sample_t b, input sample_t c,
                              input sample_t d);
    logic [31:0] rnd;
    rnd = $urandom;
    push_word(ACTION_SAMPLES, {d, c, b, a}, rnd[0]);
  endtask

  task automatic push_control(input logic ctl);
    logic [4*SAMPLE_W-1:0] junk;
    junk = {$urandom, $urandom, $urandom};
    push_word(ACTION_CONTROL, junk, ctl);
  endtask

  task automatic settle();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.awaited_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_directed();
    // reset levels and holds are all zero
    push_samples(-5, -5, 0, -5);
    push_samples(0, 0, 0, 0);
    push_samples(5, 5, 5, -1);
    push_samples(-1, -1, -1, -1);
    push_samples(-1, -1, -1, 0);
    settle();
    write_reg(REG_TRIGGER_LEVEL, SMP_MAX);
    write_reg(REG_REST_LEVEL, SMP_MIN);
    write_reg(REG_TRIGGER_HOLD, 0);
    write_reg(REG_REST_HOLD, 4);
    push_samples(SMP_MAX, SMP_MIN, SMP_MIN, SMP_MIN);
    push_control(CTRL_ARM);
    push_samples(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MAX);
    push_samples(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
    push_samples(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN);
    push_control(CTRL_WAIT_REST);
    push_samples(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
    settle();
    write_reg(REG_TRIGGER_LEVEL, SMP_MIN);
    write_reg(REG_REST_LEVEL, SMP_MAX);
    write_reg(REG_TRIGGER_HOLD, 8);
    write_reg(REG_REST_HOLD, 0);
    push_control(CTRL_ARM);
    push_samples(SMP_MIN, SMP_MAX, SMP_MAX, SMP_MAX);
    push_samples(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN);
    push_samples(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN);
    push_samples(SMP_MAX, SMP_MAX, SMP_MAX, 0);
    push_samples(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN);
    push_samples(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
    push_samples(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
    push_control(CTRL_WAIT_REST);
    push_samples(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
    push_samples(SMP_MAX, SMP_MAX, 24'sh7FFFFE, SMP_MAX);
    settle();
    write_reg(REG_TRIGGER_HOLD, HOLD_MAX);
    push_control(CTRL_ARM);
    push_samples(0, 0, 0, 0);
    push_samples(0, 0, 0, 0);
    push_samples(0, 0, 0, 0);
    settle();
    // shrink the hold while it runs
    write_reg(REG_TRIGGER_HOLD, 4);
    push_samples(0, 0, 0, 0);
    push_samples(0, 0, 0, 0);
    settle();
  endtask

  task automatic setup_phase(input int p);
    logic [31:0] rnd;
    sample_t trig;
    rnd = $urandom;
    trig = rnd[SAMPLE_W-1:0];
    case (p)
      0: begin
        write_reg(REG_TRIGGER_LEVEL, 1000);
        write_reg(REG_REST_LEVEL, -1000);
        write_reg(REG_TRIGGER_HOLD, 0);
        write_reg(REG_REST_HOLD, 0);
      end
      1: begin
        write_reg(REG_TRIGGER_LEVEL, trig);
        write_reg(REG_REST_LEVEL, trig - sample_t'($urandom_range(0, 5000)));
        write_reg(REG_TRIGGER_HOLD, HOLD_W'($urandom_range(0, 12)));
        write_reg(REG_REST_HOLD, HOLD_W'($urandom_range(0, 12)));
      end
      2: begin
        write_reg(REG_TRIGGER_LEVEL, SMP_MIN);
        write_reg(REG_REST_LEVEL, SMP_MAX);
        write_reg(REG_TRIGGER_HOLD, 0);
        write_reg(REG_REST_HOLD, 0);
      end
      3: begin
        write_reg(REG_TRIGGER_LEVEL, SMP_MAX);
        write_reg(REG_REST_LEVEL, SMP_MIN);
        write_reg(REG_TRIGGER_HOLD, HOLD_MAX);
        write_reg(REG_REST_HOLD, HOLD_MAX);
      end
      4: begin
        write_reg(REG_TRIGGER_LEVEL, trig);
        rnd = $urandom;
        write_reg(REG_REST_LEVEL, rnd[SAMPLE_W-1:0]);
        write_reg(REG_TRIGGER_HOLD, HOLD_W'($urandom_range(0, 40)));
        write_reg(REG_REST_HOLD, HOLD_W'($urandom_range(0, 40)));
      end
      5: begin
        write_reg(REG_TRIGGER_LEVEL, trig);
        write_reg(REG_REST_LEVEL, trig);
        write_reg(REG_TRIGGER_HOLD, 3);
        write_reg(REG_REST_HOLD, 5);
      end
      6: begin
        write_reg(REG_TRIGGER_LEVEL, -2000);
        write_reg(REG_REST_LEVEL, 2000);
        write_reg(REG_TRIGGER_HOLD, 1);
        write_reg(REG_REST_HOLD, 7);
      end
      default: begin
        write_reg(REG_TRIGGER_LEVEL, trig);
        write_reg(REG_REST_LEVEL, trig - sample_t'($urandom_range(0, 300)));
        write_reg(REG_TRIGGER_HOLD, 8);
        write_reg(REG_REST_HOLD, HOLD_MAX);
      end
    endcase
  endtask

  task automatic run_random(input int count);
    logic [4*SAMPLE_W-1:0] smp;
    logic [31:0] rnd;
    sample_t lane;
    int sel;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        rnd = $urandom;
        push_control(rnd[0]);
      end else begin
        for (int i = 0; i < 4; i++) begin
          rnd = $urandom;
          sel = $urandom_range(0, 9);
          if (sel < 4) begin
            lane = sb.trig_lvl + sample_t'($urandom_range(0, 16)) - sample_t'(8);
          end else if (sel < 7) begin
            lane = sb.rest_lvl + sample_t'($urandom_range(0, 16)) - sample_t'(8);
          end else if (sel == 7) begin
            lane = rnd[0] ? SMP_MAX : SMP_MIN;
          end else begin
            lane = rnd[SAMPLE_W-1:0];
          end
          smp[i*SAMPLE_W +: SAMPLE_W] = lane;
        end
        rnd = $urandom;
        push_word(ACTION_SAMPLES, smp, rnd[0]);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      setup_phase(p);
      gaps_on = (p % 3 != 1);
      if (p == 0 || p == 2) begin
        squeeze_req++;
      end
      run_random(WORDS_PER_PHASE);
      settle();
    end
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
